### hdl/fss_pkg.sv
`timescale 1ns / 1ps
package fss_pkg;
	localparam int POS_W      = 24;
	localparam int DIFF_W     = 25;
	localparam int L2_W       = 50;
	localparam int MD_W       = 16;
	localparam int MS_W       = 24;
	localparam int NUM_W      = 56;
	localparam int DEN_W      = 50;
	localparam int QUO_W      = 25;
	localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
	localparam int TERM_SH    = 24;
	localparam int NORM_W     = 31;
	localparam int ROOT_W     = 32;
	localparam int RAD_W      = 64;
	localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);
	localparam int CFG_IDX_W  = 1;
	localparam int QDEPTH     = 2;
	localparam int PTR_W      = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 1'd1;

	localparam logic [MS_W-1:0] MAX_SPEED_RST = 24'd256;
	localparam logic [MD_W-1:0] MIN_DIST_RST  = 16'd1;

	localparam logic [POS_W-1:0] VEL_MAX = 24'h7FFFFF;
	localparam logic [POS_W-1:0] VEL_MIN = 24'h800000;

	typedef struct packed {
		logic [DIFF_W-1:0] dx;
		logic [DIFF_W-1:0] dy;
		logic [L2_W-1:0]   l2;
		logic              skip;
		logic              last;
		logic              empty;
	} job_t;
endpackage

### hdl/fss_in_if.sv
`timescale 1ns / 1ps
interface fss_in_if;
	logic                        valid;
	logic                        ready;
	logic [fss_pkg::POS_W-1:0]   agent_x;
	logic [fss_pkg::POS_W-1:0]   agent_y;
	logic [fss_pkg::POS_W-1:0]   neighbor_x;
	logic [fss_pkg::POS_W-1:0]   neighbor_y;
	logic                        last_neighbor;
	logic                        no_neighbors;
	modport source(output valid, agent_x, agent_y, neighbor_x, neighbor_y, last_neighbor,
		no_neighbors, input ready);
	modport sink(input valid, agent_x, agent_y, neighbor_x, neighbor_y, last_neighbor,
		no_neighbors, output ready);
endinterface

### hdl/fss_out_if.sv
`timescale 1ns / 1ps
interface fss_out_if;
	logic                      valid;
	logic                      ready;
	logic [fss_pkg::POS_W-1:0] vel_x;
	logic [fss_pkg::POS_W-1:0] vel_y;
	logic                      valid_res;
	modport source(output valid, vel_x, vel_y, valid_res, input ready);
	modport sink(input valid, vel_x, vel_y, valid_res, output ready);
endinterface

### hdl/fss_cfg_if.sv
`timescale 1ns / 1ps
interface fss_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fss_pkg::CFG_IDX_W-1:0] index;
	logic [fss_pkg::MS_W-1:0]      data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hdl/fss_front.sv
`timescale 1ns / 1ps
module fss_front (
	input  logic                     clk,
	input  logic                     arst_n,
	fss_in_if.sink                   nbr,
	input  logic [fss_pkg::MD_W-1:0] min_distance,
	input  logic                     full,
	output logic                     push,
	output fss_pkg::job_t            push_job
);
	import fss_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_SQ   = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]          state_q;
	logic [DIFF_W-1:0]   dx_s1, dy_s1;
	logic                last_s1, empty_s1;
	logic [DIFF_W-1:0]   ux, uy;
	logic [L2_W-1:0]     ux2_s2, uy2_s2;
	logic [2*MD_W-1:0]   md2_s2;
	logic [L2_W-1:0]     l2;

	assign nbr.ready = (state_q == F_IDLE);
	assign ux = dx_s1[DIFF_W-1] ? -dx_s1 : dx_s1;
	assign uy = dy_s1[DIFF_W-1] ? -dy_s1 : dy_s1;
	assign l2 = ux2_s2 + uy2_s2;
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		push_job.dx    = dx_s1;
		push_job.dy    = dy_s1;
		push_job.l2    = l2;
		push_job.skip  = (l2 == '0) || (l2 < L2_W'(md2_s2));
		push_job.last  = last_s1;
		push_job.empty = empty_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (nbr.valid) state_q <= F_SQ;
				F_SQ:   state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && nbr.valid) begin
			dx_s1    <= {nbr.neighbor_x[POS_W-1], nbr.neighbor_x}
				- {nbr.agent_x[POS_W-1], nbr.agent_x};
			dy_s1    <= {nbr.neighbor_y[POS_W-1], nbr.neighbor_y}
				- {nbr.agent_y[POS_W-1], nbr.agent_y};
			last_s1  <= nbr.last_neighbor;
			empty_s1 <= nbr.no_neighbors;
		end
		if (state_q == F_SQ) begin
			ux2_s2 <= L2_W'(ux) * L2_W'(ux);
			uy2_s2 <= L2_W'(uy) * L2_W'(uy);
			md2_s2 <= (2*MD_W)'(min_distance) * (2*MD_W)'(min_distance);
		end
	end
endmodule

### hdl/fss_queue.sv
`timescale 1ns / 1ps
module fss_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fss_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output fss_pkg::job_t head
);
	import fss_pkg::*;

	job_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full      = (cnt_q == (PTR_W+1)'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue read while empty");
endmodule

### hdl/fss_div.sv
`timescale 1ns / 1ps
module fss_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fss_pkg::NUM_W-1:0]  num,
	input  logic [fss_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [fss_pkg::QUO_W-1:0]  quo
);
	import fss_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q, den_q;
	logic [QUO_W-1:0]     low_q, quo_q;
	logic [DEN_W:0]       trial, diff;
	logic                 ge;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num[NUM_W-1:QUO_W]);
			low_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end
endmodule

### hdl/fss_back.sv
`timescale 1ns / 1ps
module fss_back #(
	parameter int SUM_WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  fss_pkg::job_t            q_job,
	output logic                     pop,
	input  logic [fss_pkg::MS_W-1:0] max_speed,
	fss_out_if.source                steer
);
	import fss_pkg::*;

	localparam int SW = SUM_WIDTH;
	localparam logic [3:0] B_IDLE   = 4'd0;
	localparam logic [3:0] B_TERM   = 4'd1;
	localparam logic [3:0] B_TWAIT  = 4'd2;
	localparam logic [3:0] B_ACC    = 4'd3;
	localparam logic [3:0] B_CHK    = 4'd4;
	localparam logic [3:0] B_NORM   = 4'd5;
	localparam logic [3:0] B_SQ     = 4'd6;
	localparam logic [3:0] B_SSUM   = 4'd7;
	localparam logic [3:0] B_ROOT   = 4'd8;
	localparam logic [3:0] B_FSTART = 4'd9;
	localparam logic [3:0] B_FWAIT  = 4'd10;
	localparam logic [3:0] B_FIN    = 4'd11;
	localparam logic [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

	logic [3:0]            state_q;
	job_t                  job_q;
	logic [SW-1:0]         sum_x_q, sum_y_q;
	logic [SW-1:0]         mx_q, my_q;
	logic [2*NORM_W-1:0]   sqx_s1, sqy_s1;
	logic [NUM_W-1:0]      px_q, py_q;
	logic [RAD_W-1:0]      rad_q, root_q, bit_q;
	logic [ROOT_CNT_W-1:0] it_q;
	logic [POS_W-1:0]      vx_q, vy_q;
	logic                  ok_q;
	logic                  out_valid_q, out_ok_q;
	logic [POS_W-1:0]      out_vx_q, out_vy_q;

	logic [DIFF_W-1:0]     ux, uy;
	logic [NUM_W-1:0]      num_x, num_y, mxe, mye, mse;
	logic [DEN_W-1:0]      den;
	logic [ROOT_W-1:0]     n1;
	logic                  div_start, in_term, done_x, done_y;
	logic [QUO_W-1:0]      quo_x, quo_y;
	logic [SW-1:0]         tx, ty, acc_x, acc_y, mag_x, mag_y, m;
	logic                  m_big, m_small, out_load;
	logic [RAD_W-1:0]      rtrial;
	logic [2*NORM_W-1:0]   sqxe, sqye;

	function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {a[SW-1], a} + {b[SW-1], b};
		if (s[SW] != s[SW-1]) return s[SW] ? SUM_MIN : SUM_MAX;
		return s[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] term(input logic [QUO_W-1:0] q,
			input logic [DIFF_W-1:0] d);
		logic [SW-1:0] e;
		e = SW'(q);
		return (!d[DIFF_W-1] && d != '0) ? -e : e;
	endfunction

	function automatic logic [POS_W-1:0] vel_sat(input logic [QUO_W-1:0] q, input logic neg);
		logic [QUO_W-1:0] nq;
		nq = ~q + 1'b1;
		if (neg) return (q > QUO_W'(VEL_MIN)) ? VEL_MIN : nq[POS_W-1:0];
		return (q > QUO_W'(VEL_MAX)) ? VEL_MAX : q[POS_W-1:0];
	endfunction

	assign ux      = job_q.dx[DIFF_W-1] ? -job_q.dx : job_q.dx;
	assign uy      = job_q.dy[DIFF_W-1] ? -job_q.dy : job_q.dy;
	assign n1      = (root_q[ROOT_W-1:0] == '0) ? ROOT_W'(1) : root_q[ROOT_W-1:0];
	assign in_term = (state_q == B_TERM);
	assign num_x   = in_term ? (NUM_W'(ux) << TERM_SH) : px_q;
	assign num_y   = in_term ? (NUM_W'(uy) << TERM_SH) : py_q;
	assign den     = in_term ? job_q.l2 : DEN_W'(n1);
	assign div_start = in_term || (state_q == B_FSTART);
	assign tx      = term(quo_x, job_q.dx);
	assign ty      = term(quo_y, job_q.dy);
	assign acc_x   = sat_add(sum_x_q, tx);
	assign acc_y   = sat_add(sum_y_q, ty);
	assign mag_x   = sum_x_q[SW-1] ? -sum_x_q : sum_x_q;
	assign mag_y   = sum_y_q[SW-1] ? -sum_y_q : sum_y_q;
	assign m       = (mx_q > my_q) ? mx_q : my_q;
	assign m_big   = |m[SW-1:NORM_W];
	assign m_small = !m_big && !m[NORM_W-1];
	assign mxe     = NUM_W'(mx_q[NORM_W-1:0]);
	assign mye     = NUM_W'(my_q[NORM_W-1:0]);
	assign mse     = NUM_W'(max_speed);
	assign sqxe    = (2*NORM_W)'(mx_q[NORM_W-1:0]);
	assign sqye    = (2*NORM_W)'(my_q[NORM_W-1:0]);
	assign rtrial  = root_q + bit_q;
	assign out_load = (state_q == B_FIN) && (!out_valid_q || steer.ready);
	assign pop     = (state_q == B_IDLE) && q_valid;

	assign steer.valid     = out_valid_q;
	assign steer.vel_x     = out_vx_q;
	assign steer.vel_y     = out_vy_q;
	assign steer.valid_res = out_ok_q;

	fss_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_x), .den(den),
		.done(done_x), .quo(quo_x)
	);
	fss_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_y), .den(den),
		.done(done_y), .quo(quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
			it_q        <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (steer.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_job.empty) state_q <= B_FIN;
						else if (q_job.skip) state_q <= B_CHK;
						else state_q <= B_TERM;
					end
				end
				B_TERM: state_q <= B_TWAIT;
				B_TWAIT: if (done_x) state_q <= B_ACC;
				B_ACC: begin
					sum_x_q <= acc_x;
					sum_y_q <= acc_y;
					state_q <= B_CHK;
				end
				B_CHK: begin
					if (!job_q.last) state_q <= B_IDLE;
					else if (sum_x_q == '0 && sum_y_q == '0) state_q <= B_FIN;
					else state_q <= B_NORM;
				end
				B_NORM: if (!m_big && !m_small) state_q <= B_SQ;
				B_SQ: state_q <= B_SSUM;
				B_SSUM: begin
					it_q    <= ROOT_CNT_W'(ROOT_W);
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					it_q <= it_q - 1'b1;
					if (it_q == ROOT_CNT_W'(1)) state_q <= B_FSTART;
				end
				B_FSTART: state_q <= B_FWAIT;
				B_FWAIT: if (done_x) state_q <= B_FIN;
				B_FIN: begin
					if (out_load) begin
						sum_x_q <= '0;
						sum_y_q <= '0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
			vx_q  <= '0;
			vy_q  <= '0;
			ok_q  <= 1'b0;
		end
		if (state_q == B_CHK) begin
			mx_q <= mag_x;
			my_q <= mag_y;
		end
		if (state_q == B_NORM) begin
			if (m_big) begin
				mx_q <= mx_q >> 1;
				my_q <= my_q >> 1;
			end else if (m_small) begin
				mx_q <= mx_q << 1;
				my_q <= my_q << 1;
			end
		end
		if (state_q == B_SQ) begin
			sqx_s1 <= sqxe * sqxe;
			sqy_s1 <= sqye * sqye;
			px_q   <= mxe * mse;
			py_q   <= mye * mse;
		end
		if (state_q == B_SSUM) begin
			rad_q  <= RAD_W'(sqx_s1) + RAD_W'(sqy_s1);
			root_q <= '0;
			bit_q  <= RAD_W'(1) << (RAD_W - 2);
		end
		if (state_q == B_ROOT) begin
			if (rad_q >= rtrial) begin
				rad_q  <= rad_q - rtrial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == B_FWAIT && done_x) begin
			vx_q <= vel_sat(quo_x, sum_x_q[SW-1]);
			vy_q <= vel_sat(quo_y, sum_y_q[SW-1]);
			ok_q <= 1'b1;
		end
		if (out_load) begin
			out_vx_q <= vx_q;
			out_vy_q <= vy_q;
			out_ok_q <= ok_q;
		end
	end

	a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		done_x |-> (state_q == B_TWAIT || state_q == B_FWAIT))
		else $error("divider finished outside a wait state");
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n) done_x == done_y)
		else $error("divider lanes out of step");
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (sum_x_q == '0 && sum_y_q == '0))
		else $error("push sum not cleared after a result");
endmodule

### hdl/flock_separation_steer.sv
// Separation steering for one flocking agent. Each neighbor word carries the agent and one
// neighbor position (signed Q16.8); neighbors nearer than min_distance, or at zero offset,
// are dropped, the rest add an inverse-square push to a saturating SUM_WIDTH-bit sum, and the
// word marked last_neighbor (or no_neighbors) yields one result word: the push rescaled to
// length max_speed, or valid_res low with zero velocity when the push is zero or the run is
// empty. A kept neighbor holds the back end for one pass of the 25-step shared divider pair;
// a dropped neighbor skips the divide. The closing word adds normalising shifts, a 32-step
// square root and a second 25-step divide. The front end and a 2-deep queue run ahead of
// this. The result register frees the back end at once unless an earlier result word still
// waits there, in which case the back end holds until it is taken.
`timescale 1ns / 1ps
module flock_separation_steer #(
	parameter int SUM_WIDTH = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	fss_in_if.sink    nbr,
	fss_out_if.source steer,
	fss_cfg_if.sink   cfg
);
	import fss_pkg::*;

	logic [MS_W-1:0] max_speed_q;
	logic [MD_W-1:0] min_dist_q;
	logic            push, full, pop, not_empty;
	job_t            push_job, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			min_dist_q  <= MIN_DIST_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_SPEED: max_speed_q <= cfg.data;
				REG_MIN_DIST:  min_dist_q  <= cfg.data[MD_W-1:0];
				default: ;
			endcase
		end
	end

	fss_front u_front (
		.clk(clk), .arst_n(arst_n), .nbr(nbr), .min_distance(min_dist_q),
		.full(full), .push(push), .push_job(push_job)
	);

	fss_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .full(full),
		.pop(pop), .not_empty(not_empty), .head(head)
	);

	fss_back #(.SUM_WIDTH(SUM_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(not_empty), .q_job(head), .pop(pop),
		.max_speed(max_speed_q), .steer(steer)
	);
endmodule

### tb/fss_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are taken from the RTL files; this file holds the shared word type.
package fss_tb_pkg;
	typedef struct {
		logic [23:0] vx;
		logic [23:0] vy;
		logic        ok;
	} steer_word_t;
endpackage

### tb/fss_checker.sv
`timescale 1ns / 1ps
module fss_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [23:0] ax,
	input  logic [23:0] ay,
	input  logic [23:0] nx,
	input  logic [23:0] ny,
	input  logic        last,
	input  logic        empty,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] vel_x,
	input  logic [23:0] vel_y,
	input  logic        valid_res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen
);
	import fss_pkg::*;
	import fss_tb_pkg::*;

	localparam longint SUM_HI = (64'sd1 <<< 47) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;

	longint unsigned speed_reg;
	longint unsigned dist_reg;
	longint sum_x;
	longint sum_y;
	steer_word_t steer_q[$];

	assign pending = steer_q.size();

	function automatic longint sat_sum(longint a, longint b);
		if (b > 0 && a > SUM_HI - b) return SUM_HI;
		if (b < 0 && a < SUM_LO - b) return SUM_LO;
		return a + b;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint push_term(longint d, longint unsigned l2);
		longint unsigned q;
		q = (magnitude(d) << 24) / l2;
		return d > 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [23:0] scale_axis(longint unsigned m, longint unsigned n,
		longint s);
		longint unsigned q;
		longint v;
		q = m * speed_reg / n;
		if (s < 0) v = q > 64'd8388608 ? -64'sd8388608 : -longint'(q);
		else v = q > 64'd8388607 ? 64'sd8388607 : longint'(q);
		return v[23:0];
	endfunction

	task automatic predict_push(input logic [23:0] pax, pay, pnx, pny, input logic pl, pe);
		longint dx, dy;
		longint unsigned l2, mx, my, m, n;
		steer_word_t w;
		if (!pe) begin
			dx = longint'($signed(pnx)) - longint'($signed(pax));
			dy = longint'($signed(pny)) - longint'($signed(pay));
			l2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
			if (l2 != 0 && l2 >= dist_reg * dist_reg) begin
				sum_x = sat_sum(sum_x, push_term(dx, l2));
				sum_y = sat_sum(sum_y, push_term(dy, l2));
			end
			if (!pl) return;
		end
		w.vx = '0;
		w.vy = '0;
		w.ok = 1'b0;
		if (!pe && (sum_x != 0 || sum_y != 0)) begin
			mx = magnitude(sum_x);
			my = magnitude(sum_y);
			m = mx > my ? mx : my;
			while (m >= (64'd1 << 31)) begin
				mx >>= 1; my >>= 1; m >>= 1;
			end
			while (m < (64'd1 << 30)) begin
				mx <<= 1; my <<= 1; m <<= 1;
			end
			n = root_floor(mx * mx + my * my);
			if (n == 0) n = 1;
			w.vx = scale_axis(mx, n, sum_x);
			w.vy = scale_axis(my, n, sum_y);
			w.ok = 1'b1;
		end
		sum_x = 0;
		sum_y = 0;
		steer_q.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		steer_word_t e;
		if (!arst_n) begin
			speed_reg = MAX_SPEED_RST;
			dist_reg = MIN_DIST_RST;
			sum_x = 0;
			sum_y = 0;
			steer_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_SPEED) speed_reg = cfg_data;
				else if (cfg_index == REG_MIN_DIST) dist_reg = cfg_data[15:0];
			end
			if (in_valid && in_ready) predict_push(ax, ay, nx, ny, last, empty);
			if (out_valid && out_ready) begin
				results_seen++;
				if (steer_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word vx=%h vy=%h ok=%b", $time, vel_x, vel_y,
						valid_res);
				end else begin
					e = steer_q.pop_front();
					if (e.vx !== vel_x || e.vy !== vel_y || e.ok !== valid_res) begin
						errors++;
						$display("%0t: mismatch expected vx=%h vy=%h ok=%b actual vx=%h vy=%h ok=%b",
							$time, e.vx, e.vy, e.ok, vel_x, vel_y, valid_res);
					end
				end
			end
		end
	end
endmodule

### tb/flock_separation_steer_test.sv
`timescale 1ns / 1ps
module flock_separation_steer_test;
	import fss_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	int errors, pending, results_seen, idle_cycles, items_sent;

	fss_in_if nbr ();
	fss_out_if steer ();
	fss_cfg_if cfg ();

	flock_separation_steer dut (
		.clk(clk), .arst_n(arst_n), .nbr(nbr), .steer(steer), .cfg(cfg)
	);

	fss_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(nbr.valid), .in_ready(nbr.ready),
		.ax(nbr.agent_x), .ay(nbr.agent_y), .nx(nbr.neighbor_x), .ny(nbr.neighbor_y),
		.last(nbr.last_neighbor), .empty(nbr.no_neighbors),
		.out_valid(steer.valid), .out_ready(steer.ready),
		.vel_x(steer.vel_x), .vel_y(steer.vel_y), .valid_res(steer.valid_res),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// hold the receiver ready low at random
	initial begin
		steer.ready = 0;
		@(negedge clk);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) steer.ready = 0;
			else steer.ready = 1;
			if ($urandom_range(0, 60) == 0) begin
				steer.ready = 0;
				repeat ($urandom_range(10, 80)) @(negedge clk);
			end
		end
	end

	// watchdog: advance a count on cycles with no accepted word
	always @(posedge clk) begin
		if ((nbr.valid && nbr.ready) || (steer.valid && steer.ready) || (cfg.valid && cfg.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic [23:0] ax, ay, nx, ny, input logic l, e);
		repeat (gap_len()) @(negedge clk);
		nbr.agent_x = ax; nbr.agent_y = ay;
		nbr.neighbor_x = nx; nbr.neighbor_y = ny;
		nbr.last_neighbor = l; nbr.no_neighbors = e;
		nbr.valid = 1;
		@(posedge clk);
		while (!nbr.ready) @(posedge clk);
		@(negedge clk);
		nbr.valid = 0;
		items_sent++;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
		drain();
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	function automatic logic [23:0] rand_pos(input int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 24'($urandom);
		if (r == 1) return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
		return 24'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_run(input int span);
		logic [23:0] ax, ay;
		int cnt;
		ax = rand_pos(span);
		ay = rand_pos(span);
		if ($urandom_range(0, 12) == 0) begin
			send_word(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				1'($urandom), 1);
			return;
		end
		cnt = $urandom_range(1, 6);
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_word(ax, ay, ax, ay, i == cnt - 1, 0);
			else
				send_word(ax, ay, 24'(ax + rand_pos(span)), 24'(ay + rand_pos(span)),
					i == cnt - 1, 0);
		end
	endtask

	initial begin
		arst_n = 0;
		nbr.valid = 0; nbr.agent_x = 0; nbr.agent_y = 0; nbr.neighbor_x = 0;
		nbr.neighbor_y = 0; nbr.last_neighbor = 0; nbr.no_neighbors = 0;
		cfg.valid = 0; cfg.index = REG_MAX_SPEED; cfg.data = 0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, zero offset, empty runs, reset settings
		send_word(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1, 0);
		send_word(24'h7FFFFF, 24'h000000, 24'h800000, 24'h000000, 1, 0);
		send_word(24'h000100, 24'h000100, 24'h000100, 24'h000100, 1, 0);
		send_word(24'h000000, 24'h000000, 24'h000001, 24'h000000, 0, 0);
		send_word(24'h000000, 24'h000000, 24'hFFFFFF, 24'h000001, 1, 0);
		send_word(24'h123456, 24'h654321, 24'hABCDEF, 24'hFEDCBA, 1, 1);
		send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1);
		for (int i = 0; i < 4; i++)
			send_word(0, 0, 24'(1 << i), 24'(-(3 << i)), i == 3, 0);
		write_reg(REG_MIN_DIST, 24'h000000);
		send_word(0, 0, 0, 0, 1, 0);
		send_word(0, 0, 24'h000001, 24'h000001, 1, 0);
		write_reg(REG_MIN_DIST, 24'hFFFFFF);
		send_word(0, 0, 24'h000100, 0, 1, 0);
		send_word(24'h800000, 0, 24'h7FFFFF, 24'h7FFFFF, 1, 0);
		write_reg(REG_MAX_SPEED, 24'h000000);
		write_reg(REG_MIN_DIST, 24'h000100);
		send_word(0, 0, 24'h000500, 24'hFFF000, 1, 0);
		write_reg(REG_MAX_SPEED, 24'hFFFFFF);
		send_word(0, 0, 24'h000500, 24'hFFF000, 1, 0);
		send_word(0, 0, 24'h000000, 24'h800000, 1, 0);
		// add up the push of six close neighbors in one run
		write_reg(REG_MIN_DIST, 24'h000000);
		for (int i = 0; i < 6; i++) send_word(0, 0, 24'h000001, 0, i == 5, 0);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(REG_MAX_SPEED, 24'h000100); write_reg(REG_MIN_DIST, 1); end
				1: begin write_reg(REG_MAX_SPEED, 24'($urandom)); write_reg(REG_MIN_DIST, 0); end
				2: begin
					write_reg(REG_MAX_SPEED, 24'hFFFFFF);
					write_reg(REG_MIN_DIST, 24'($urandom_range(0, 2000)));
				end
				3: begin write_reg(REG_MAX_SPEED, 24'h000001); write_reg(REG_MIN_DIST, 24'hFFFF); end
				4: begin
					write_reg(REG_MAX_SPEED, 24'($urandom));
					write_reg(REG_MIN_DIST, 24'($urandom));
				end
				default: begin write_reg(REG_MAX_SPEED, 0); write_reg(REG_MIN_DIST, 16); end
			endcase
			while (items_sent < 25 + (phase + 1) * 148) begin
				random_run(phase == 3 ? 8000000 : (phase % 2 ? 4096 : 65536));
				if ($urandom_range(0, 40) == 0) drain();
			end
		end

		drain();
		$display("Sent %0d neighbor words over six settings; %0d steering words checked.",
			items_sent, results_seen);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
